### src/lbin_pkg.sv
// Package for the linear binning block: constants, codes and item types.
// Used by lbin_div and linear_binning_1d; depends on nothing else.
`default_nettype none
package lbin_pkg;

  localparam int unsigned MAX_BINS    = 256;
  localparam int unsigned STORE_DEPTH = MAX_BINS + 1;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [47:0] W48_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [23:0] MEAN_MAX = 24'h7F_FFFF;
  localparam logic [23:0] MEAN_MIN = 24'h80_0000;

  typedef enum logic [1:0] {
    REG_GRID_START = 2'd0,
    REG_BIN_WIDTH  = 2'd1,
    REG_BIN_SCALE  = 2'd2,
    REG_BIN_COUNT  = 2'd3
  } lbin_reg_e;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_RSVD  = 2'd3
  } lbin_mode_e;

  typedef enum logic [1:0] {
    STAT_ADDED   = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_READ    = 2'd2,
    STAT_EMPTY   = 2'd3
  } lbin_status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHK, S_YMUL, S_ACC_LO, S_ACC_HI, S_RD, S_DIV, S_FIN
  } lbin_state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] x_position;
    logic signed [23:0] y_value;
    logic [15:0]        weight;
    logic [8:0]         bin_select;
  } lbin_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         bin_index;
    logic signed [31:0] grid_x;
    logic [47:0]        weight_sum;
    logic signed [63:0] y_sum;
    logic signed [23:0] y_mean;
  } lbin_out_t;

endpackage
`default_nettype wire

### src/linear_binning_1d.sv
// Top level of the linear binning block: sequencer, bin memories, arithmetic.
// Depends on lbin_pkg and lbin_div.
`default_nettype none
// Usage.
// Items enter on in_i when start is high and busy is low. An add item places
// a weighted point between two adjacent grid points; a read item returns one
// grid point's sums and mean y, and a clear read also empties that point.
// Every item gives exactly one result on res_o, shown for one cycle with
// res_valid_o high. The receiver cannot stall, so results are never held.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; ready is always high and writes are meant for idle periods.
// The path from acceptance to the result strobe: an add goes through S_MUL,
// S_CHK, S_YMUL, S_ACC_LO and S_ACC_HI, or skips S_ACC_HI on the last grid
// point; a dropped point leaves after S_CHK; a read goes through S_RD, and
// through S_DIV when it needs a mean; S_FIN then loads the result. An add is a
// read-modify-write of two entries through a single-port-write memory with a
// registered read, preceded by a multiply stage, a share multiply and a y
// multiply; the mean uses a bit-serial divider. One item is worked at a
// time: busy stays high from acceptance until the result strobe rises, and the
// next item can be accepted at the edge that takes the result.
// Reset sets the control and configuration registers and clears the per-entry
// valid bits, so every grid point reads as zero right away; no clearing pass is needed.
module linear_binning_1d (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire lbin_pkg::lbin_in_t in_i,
  output logic                   res_valid_o,
  output lbin_pkg::lbin_out_t    res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);
  import lbin_pkg::*;

  // Configuration registers.
  logic [31:0] grid_start_q, bin_width_q, bin_scale_q;
  logic [8:0]  bin_count_q;
  logic [8:0]  eff_cnt;

  // Sequencer.
  lbin_state_e state_q, state_d;

  // Item and working registers.
  lbin_in_t    item_q;
  logic        dneg_q;
  logic [63:0] prod_q;
  logic [ADDR_W-1:0] idx_q;
  logic        last_q;
  logic [32:0] share_lo_q;
  logic [31:0] share_hi_q;
  logic signed [57:0] ylo_q, yhi_q;
  logic [40:0] gprod_q;
  logic [1:0]  stat_q;
  logic [47:0] ws_q;
  logic signed [63:0] ys_q;
  logic signed [23:0] mean_q;

  // Result registers.
  lbin_out_t res_q;
  logic      res_valid_q;

  // Bin memories with per-entry valid bits.
  logic [47:0] wmem [STORE_DEPTH];
  logic [63:0] ymem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [47:0] rd_w_q;
  logic [63:0] rd_y_q;
  logic        rd_v_q;
  logic [47:0] rd_w;
  logic signed [63:0] rd_y;

  logic              rd_en, wr_en, clr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [47:0]       wr_w;
  logic [63:0]       wr_y;

  // Datapath helpers.
  logic signed [32:0] dx;
  logic [33:0] idx_full;
  logic [15:0] frac;
  logic        drop;
  logic [48:0] wsum_lo, wsum_hi;
  logic signed [64:0] ysum_lo, ysum_hi;
  logic [47:0] new_w_lo, new_w_hi;
  logic [63:0] new_y_lo, new_y_hi;
  logic signed [41:0] gsum;
  logic [31:0] grid_sat;
  logic        sel_in_store;
  logic        div_start, div_done;
  logic signed [23:0] div_mean;
  logic        accept;

  assign accept       = start && !busy;
  assign busy         = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;
  assign sel_in_store = (item_q.bin_select <= 9'(MAX_BINS));

  always_comb begin
    if (bin_count_q == 9'd0) begin
      eff_cnt = 9'd1;
    end else if (bin_count_q > 9'(MAX_BINS)) begin
      eff_cnt = 9'(MAX_BINS);
    end else begin
      eff_cnt = bin_count_q;
    end
  end

  // Position and range check.
  assign dx       = {item_q.x_position[31], item_q.x_position}
                  - {grid_start_q[31], grid_start_q};
  assign idx_full = {2'b00, prod_q[63:32]};
  assign frac     = prod_q[31:16];
  assign drop     = dneg_q || (idx_full > {25'd0, eff_cnt})
                  || ((idx_full == {25'd0, eff_cnt}) && (frac != 16'd0));

  // Entries that were never written, or were cleared, read as zero.
  assign rd_w = rd_v_q ? rd_w_q : 48'd0;
  assign rd_y = rd_v_q ? $signed(rd_y_q) : 64'sd0;

  // Saturating accumulation for the lower and upper grid points.
  assign wsum_lo  = {1'b0, rd_w} + {16'd0, share_lo_q};
  assign wsum_hi  = {1'b0, rd_w} + {17'd0, share_hi_q};
  assign new_w_lo = wsum_lo[48] ? W48_MAX : wsum_lo[47:0];
  assign new_w_hi = wsum_hi[48] ? W48_MAX : wsum_hi[47:0];
  assign ysum_lo  = {rd_y[63], rd_y} + 65'(ylo_q);
  assign ysum_hi  = {rd_y[63], rd_y} + 65'(yhi_q);
  assign new_y_lo = (ysum_lo[64] != ysum_lo[63])
                  ? (ysum_lo[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : ysum_lo[63:0];
  assign new_y_hi = (ysum_hi[64] != ysum_hi[63])
                  ? (ysum_hi[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : ysum_hi[63:0];

  // Grid position, saturated to 32 bits signed.
  assign gsum = {{10{grid_start_q[31]}}, grid_start_q} + $signed({1'b0, gprod_q});
  always_comb begin
    if (gsum > 42'sd2147483647) begin
      grid_sat = 32'h7FFF_FFFF;
    end else if (gsum < -42'sd2147483648) begin
      grid_sat = 32'h8000_0000;
    end else begin
      grid_sat = gsum[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_i.mode == MODE_ADD) ? S_MUL : S_RD;
        end
      end
      S_MUL:    state_d = S_CHK;
      S_CHK:    state_d = drop ? S_FIN : S_YMUL;
      S_YMUL:   state_d = S_ACC_LO;
      S_ACC_LO: state_d = last_q ? S_FIN : S_ACC_HI;
      S_ACC_HI: state_d = S_FIN;
      S_RD: begin
        if (!sel_in_store || rd_w == 48'd0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:    state_d = div_done ? S_FIN : S_DIV;
      S_FIN:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_w      = new_w_lo;
    wr_y      = new_y_lo;
    clr_en    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && in_i.mode != MODE_ADD && in_i.bin_select <= 9'(MAX_BINS)) begin
          rd_en   = 1'b1;
          rd_addr = in_i.bin_select[ADDR_W-1:0];
        end
      end
      S_YMUL: rd_en = 1'b1;
      S_ACC_LO: begin
        wr_en = 1'b1;
        if (!last_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end
      S_ACC_HI: begin
        wr_en   = 1'b1;
        wr_addr = idx_q + 1'b1;
        wr_w    = new_w_hi;
        wr_y    = new_y_hi;
      end
      S_RD: begin
        clr_en    = sel_in_store && (item_q.mode == MODE_CLEAR);
        div_start = sel_in_store && (rd_w != 48'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[wr_addr] <= wr_w;
      ymem[wr_addr] <= wr_y;
    end
    if (rd_en) begin
      rd_w_q <= wmem[rd_addr];
      rd_y_q <= ymem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rd_v_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end else if (clr_en) begin
        vld_q[idx_q] <= 1'b0;
      end
      if (rd_en) begin
        rd_v_q <= vld_q[rd_addr];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_valid_q  <= 1'b0;
      grid_start_q <= 32'd0;
      bin_width_q  <= 32'd65536;
      bin_scale_q  <= 32'd65536;
      bin_count_q  <= 9'd256;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == S_FIN);
      if (cfg_valid_i && cfg_ready_o) begin
        case (lbin_reg_e'(cfg_index_i))
          REG_GRID_START: grid_start_q <= cfg_data_i;
          REG_BIN_WIDTH:  bin_width_q  <= cfg_data_i;
          REG_BIN_SCALE:  bin_scale_q  <= cfg_data_i;
          REG_BIN_COUNT:  bin_count_q  <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_q <= in_i;
          idx_q  <= in_i.bin_select[ADDR_W-1:0];
        end
      end
      S_MUL: begin
        dneg_q <= dx[32];
        prod_q <= 64'(dx[31:0]) * 64'(bin_scale_q);
      end
      S_CHK: begin
        idx_q      <= idx_full[ADDR_W-1:0];
        last_q     <= (idx_full == {25'd0, eff_cnt});
        share_lo_q <= 33'(item_q.weight) * (33'd65536 - 33'(frac));
        share_hi_q <= 32'(item_q.weight) * 32'(frac);
        stat_q     <= drop ? STAT_DROPPED : STAT_ADDED;
        ws_q       <= 48'd0;
        ys_q       <= 64'sd0;
        mean_q     <= 24'sd0;
        gprod_q    <= 41'd0;
      end
      S_YMUL: begin
        ylo_q <= 58'(item_q.y_value) * $signed({25'd0, share_lo_q});
        yhi_q <= 58'(item_q.y_value) * $signed({26'd0, share_hi_q});
      end
      S_ACC_LO: begin
        ws_q    <= new_w_lo;
        ys_q    <= new_y_lo;
        gprod_q <= 41'(idx_q) * 41'(bin_width_q);
      end
      S_RD: begin
        gprod_q <= 41'(item_q.bin_select) * 41'(bin_width_q);
        ws_q    <= sel_in_store ? rd_w : 48'd0;
        ys_q    <= sel_in_store ? rd_y : 64'sd0;
        mean_q  <= 24'sd0;
        stat_q  <= (sel_in_store && rd_w != 48'd0) ? STAT_READ : STAT_EMPTY;
      end
      S_DIV: begin
        if (div_done) begin
          mean_q <= div_mean;
        end
      end
      S_FIN: begin
        res_q.status     <= stat_q;
        res_q.bin_index  <= (stat_q == STAT_DROPPED) ? 9'd0
                          : ((item_q.mode == MODE_ADD) ? 9'(idx_q) : item_q.bin_select);
        res_q.grid_x     <= (stat_q == STAT_DROPPED) ? 32'd0 : grid_sat;
        res_q.weight_sum <= ws_q;
        res_q.y_sum      <= ys_q;
        res_q.y_mean     <= mean_q;
      end
      default: ;
    endcase
  end

  lbin_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .ysum_i  (rd_y),
    .wsum_i  (rd_w),
    .done_o  (div_done),
    .mean_o  (div_mean)
  );

  // One result per item: the strobe comes only as the sequencer returns to idle.
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy) else $error("result shown while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("item accepted without going busy");
  a_add_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == STAT_ADDED || res_o.status == STAT_DROPPED))
      |-> (res_o.y_mean == 24'sd0)) else $error("add result with nonzero mean");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr)) else $error("read and write same entry");

endmodule
`default_nettype wire

### src/lbin_div.sv
// Bit-serial signed mean divider: y sum over weight sum, saturated to 24 bits.
// Depends on lbin_pkg.
`default_nettype none
module lbin_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] ysum_i,
  input  wire logic [47:0]        wsum_i,
  output logic                    done_o,
  output logic signed [23:0]      mean_o
);
  import lbin_pkg::*;

  logic        run_q, run_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [48:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [47:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [23:0] mean_q, mean_d;
  logic [48:0] rem_sh;
  logic [63:0] quo_next;
  logic        bit_set;

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    mean_d = mean_q;
    rem_sh = {rem_q[47:0], quo_q[63]};
    bit_set = (rem_sh >= {1'b0, den_q});
    quo_next = {quo_q[62:0], bit_set};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      neg_d = ysum_i[63];
      quo_d = ysum_i[63] ? (64'd0 - ysum_i) : ysum_i;
      den_d = wsum_i;
    end else if (run_q) begin
      rem_d = bit_set ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = quo_next;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        // Truncate toward zero, then clamp to the 24-bit signed range.
        if (neg_q) begin
          mean_d = (quo_next > 64'd8388608) ? MEAN_MIN : (24'd0 - quo_next[23:0]);
        end else begin
          mean_d = (quo_next > 64'd8388607) ? MEAN_MAX : quo_next[23:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    mean_q <= mean_d;
  end

  assign done_o = done_q;
  assign mean_o = mean_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("divider done while still running");
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> run_q) else $error("divider did not start");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && cnt_q != 7'd63 && !start_i) |=> run_q) else $error("divider stopped early");

endmodule
`default_nettype wire
